// ===== rtl/drt_pkg.sv =====
// Package for the dirty range tracker: payload structs, opcodes, FSM state.
// No dependencies.
`default_nettype none
package drt_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned MaxBytesDef  = 16777216;
  localparam int unsigned AddrW        = 25;
  localparam int unsigned CntW         = 32;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_RESIZE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [AddrW-1:0] range_begin;
    logic [AddrW-1:0] range_end;
    logic [AddrW-1:0] new_size;
  } drt_in_t;

  typedef struct packed {
    logic             upload_valid;
    logic [AddrW-1:0] upload_begin;
    logic [AddrW-1:0] upload_end;
    logic             full_upload;
    logic             bound;
    logic             still_dirty;
    logic [AddrW-1:0] logical_size;
    logic [CntW-1:0]  total_uploaded;
    logic             last;
  } drt_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN,
    ST_SHIFT_REQ,
    ST_SHIFT,
    ST_FLUSH_REQ,
    ST_FLUSH,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/dirty_range_tracker.sv =====
// Top level of the dirty range tracker: APB register, control sequencer, range RAM.
// Depends on drt_pkg and drt_ram.
// Status answers via ST_DONE, a grown-cache flush straight from idle; a mark reads or moves
// RAM entries one at a time; a flush returns one range per read. Results cannot be stalled.
// One transaction at a time (a grown-cache flush never raises busy_o): busy_o is high from
// accept until the last result is registered; the next item can be accepted when it is out.
// Reset clears all control state; range RAM contents are undefined until written.
`default_nettype none
module dirty_range_tracker #(
  parameter int unsigned MaxRanges = drt_pkg::MaxRangesDef,
  parameter int unsigned MaxBytes  = drt_pkg::MaxBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire drt_pkg::drt_in_t req_i,
  output logic                  strobe_o,
  output drt_pkg::drt_out_t     res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned IdxW = $clog2(MaxRanges);
  localparam int unsigned NW   = $clog2(MaxRanges + 1);
  localparam int unsigned AW   = drt_pkg::AddrW;
  localparam logic [AW-1:0] MaxB = AW'(MaxBytes);

  logic usage_q;
  assign pready = 1'b1;
  assign prdata = {31'd0, usage_q & (paddr == 2'd0)};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      usage_q <= pwdata[0];
    end
  end

  drt_pkg::state_e st_q, st_d;
  logic [NW-1:0] cnt_q, cnt_d, i_q, i_d, lo_q, lo_d, hi_q, hi_d, w_q, w_d;
  logic alloc_q, alloc_d, dirty_q, dirty_d;
  logic [AW-1:0] dev_q, dev_d, cache_q, cache_d, size_q, size_d;
  logic [AW-1:0] b_q, b_d, e_q, e_d, nb_q, nb_d, ne_q, ne_d, pe_q, pe_d;
  // start of the lower neighbour, captured during the scan
  logic [AW-1:0] ps_q;
  logic [31:0] up_q, up_d;
  logic lof_q, lof_d;
  logic we;
  logic [IdxW-1:0] wa, ra;
  logic [2*AW-1:0] wd, rd;
  logic [AW-1:0] rs, re;
  logic [NW-1:0] rm;
  logic str;
  drt_pkg::drt_out_t o;
  logic [AW:0] ns;

  drt_ram #(.Width(2*AW), .Depth(MaxRanges)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );
  assign rs = rd[2*AW-1:AW];
  assign re = rd[AW-1:0];
  assign rm = hi_q - lo_q - NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= drt_pkg::ST_IDLE;
      cnt_q <= '0; alloc_q <= 1'b0; dirty_q <= 1'b1;
      dev_q <= '0; cache_q <= '0; size_q <= '0; up_q <= '0;
      i_q <= '0; lo_q <= '0; hi_q <= '0; w_q <= '0; lof_q <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; alloc_q <= alloc_d; dirty_q <= dirty_d;
      dev_q <= dev_d; cache_q <= cache_d; size_q <= size_d; up_q <= up_d;
      i_q <= i_d; lo_q <= lo_d; hi_q <= hi_d; w_q <= w_d; lof_q <= lof_d;
      strobe_o <= str;
    end
  end
  always_ff @(posedge clk_i) begin
    b_q <= b_d; e_q <= e_d; nb_q <= nb_d; ne_q <= ne_d; pe_q <= pe_d;
    res_o <= o;
  end

  assign busy_o = (st_q != drt_pkg::ST_IDLE);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; alloc_d = alloc_q; dirty_d = dirty_q;
    dev_d = dev_q; cache_d = cache_q; size_d = size_q; up_d = up_q;
    i_d = i_q; lo_d = lo_q; hi_d = hi_q; w_d = w_q; lof_d = lof_q;
    b_d = b_q; e_d = e_q; nb_d = nb_q; ne_d = ne_q; pe_d = pe_q;
    we = 1'b0; wa = '0; wd = '0; ra = i_q[IdxW-1:0];
    str = 1'b0; o = '0; ns = '0;
    unique case (st_q)
      drt_pkg::ST_IDLE: begin
        if (start_i) begin
          b_d = req_i.range_begin; e_d = req_i.range_end;
          i_d = '0; lo_d = '0; hi_d = '0; lof_d = 1'b0;
          unique case (drt_pkg::op_e'(req_i.opcode))
            drt_pkg::OP_MARK: begin
              if (req_i.range_begin < req_i.range_end && alloc_q &&
                  !(cache_q > dev_q)) begin
                dirty_d = 1'b1;
                st_d = drt_pkg::ST_SCAN_REQ;
              end else begin
                st_d = drt_pkg::ST_DONE;
              end
            end
            drt_pkg::OP_RESIZE: begin
              size_d = (req_i.new_size > MaxB) ? MaxB : req_i.new_size;
              ns = {1'b0, size_d} + (AW+1)'(3);
              cache_d = ns[AW-1:0] & ~AW'(3);
              st_d = drt_pkg::ST_DONE;
            end
            drt_pkg::OP_FLUSH: begin
              if (!usage_q) begin
                st_d = drt_pkg::ST_DONE;
              end else begin
                alloc_d = 1'b1;
                if (cache_q > dev_q) begin
                  cnt_d = '0; dirty_d = 1'b0; dev_d = cache_q;
                  str = 1'b1;
                  o.upload_valid = 1'b1; o.upload_end = cache_q;
                  o.full_upload = 1'b1; o.bound = 1'b1; o.still_dirty = 1'b0;
                  o.logical_size = size_q; o.total_uploaded = up_q; o.last = 1'b1;
                  st_d = drt_pkg::ST_IDLE;
                end else if (!dirty_q || cnt_q == '0) begin
                  dirty_d = 1'b0; cnt_d = '0;
                  st_d = drt_pkg::ST_DONE;
                end else begin
                  hi_d = cnt_q; cnt_d = '0; dirty_d = 1'b0;
                  st_d = drt_pkg::ST_FLUSH_REQ;
                end
              end
            end
            default: st_d = drt_pkg::ST_DONE;
          endcase
        end
      end
      drt_pkg::ST_DONE: begin
        str = 1'b1;
        o.still_dirty = dirty_q || (cache_q > dev_q);
        o.logical_size = size_q; o.total_uploaded = up_q; o.last = 1'b1;
        st_d = drt_pkg::ST_IDLE;
      end
      drt_pkg::ST_FLUSH_REQ: begin
        st_d = drt_pkg::ST_FLUSH;
      end
      drt_pkg::ST_FLUSH: begin
        up_d = up_q + 32'(re - rs);
        str = 1'b1;
        o.upload_valid = 1'b1; o.upload_begin = rs; o.upload_end = re;
        o.bound = 1'b1; o.still_dirty = cache_q > dev_q;
        o.logical_size = size_q; o.total_uploaded = up_d;
        o.last = (i_q + NW'(1) == hi_q);
        i_d = i_q + NW'(1);
        st_d = o.last ? drt_pkg::ST_IDLE : drt_pkg::ST_FLUSH_REQ;
      end
      // scan: lo = first with end >= b, hi = first from lo on with start > e
      drt_pkg::ST_SCAN_REQ: begin
        if (i_q >= cnt_q) begin
          if (!lof_q) lo_d = cnt_q;
          hi_d = cnt_q;
          st_d = drt_pkg::ST_SHIFT_REQ;
          w_d = '0;
        end else begin
          st_d = drt_pkg::ST_SCAN;
        end
      end
      drt_pkg::ST_SCAN: begin
        st_d = drt_pkg::ST_SCAN_REQ;
        i_d = i_q + NW'(1);
        if (!lof_q) begin
          if (!(re < b_q)) begin
            lof_d = 1'b1; lo_d = i_q; nb_d = (rs < b_q) ? rs : b_q;
            if (rs > e_q) begin
              hi_d = i_q; st_d = drt_pkg::ST_SHIFT_REQ; w_d = '0;
              i_d = i_q;
            end else begin
              ne_d = (re > e_q) ? re : e_q;
            end
          end else begin
            pe_d = re;
          end
        end else if (rs > e_q) begin
          hi_d = i_q; st_d = drt_pkg::ST_SHIFT_REQ; w_d = '0; i_d = i_q;
        end else begin
          ne_d = (re > e_q) ? re : e_q;
        end
        if (st_d == drt_pkg::ST_SHIFT_REQ) begin
          i_d = i_q;
        end
      end
      drt_pkg::ST_SHIFT_REQ: begin
        // w_q == 0: decide; then copy/insert entries one at a time through ST_SHIFT
        if (w_q == '0) begin
          if (lo_q < hi_q) begin
            we = 1'b1; wa = lo_q[IdxW-1:0]; wd = {nb_q, ne_q};
            cnt_d = cnt_q - rm;
            if (rm == '0) begin
              st_d = drt_pkg::ST_DONE;
            end else begin
              i_d = lo_q + NW'(1); w_d = NW'(1);
            end
          end else if (cnt_q >= NW'(MaxRanges)) begin
            we = 1'b1;
            if (lo_q == '0 || (lo_q < cnt_q && (b_q - pe_q) > (rs - e_q))) begin
              wa = lo_q[IdxW-1:0]; wd = {b_q, re};
            end else begin
              wa = IdxW'(lo_q - NW'(1)); wd = {ps_q, e_q};
            end
            st_d = drt_pkg::ST_DONE;
          end else begin
            i_d = cnt_q; w_d = NW'(2);
            if (cnt_q == lo_q) begin
              we = 1'b1; wa = lo_q[IdxW-1:0]; wd = {b_q, e_q};
              cnt_d = cnt_q + NW'(1); st_d = drt_pkg::ST_DONE;
            end
          end
        end else if (w_q == NW'(1)) begin
          if (i_q + rm >= cnt_q + rm || i_q >= cnt_q) begin
            st_d = drt_pkg::ST_DONE;
          end else begin
            ra = IdxW'(i_q + rm); st_d = drt_pkg::ST_SHIFT;
          end
        end else begin
          if (i_q == lo_q) begin
            we = 1'b1; wa = lo_q[IdxW-1:0]; wd = {b_q, e_q};
            cnt_d = cnt_q + NW'(1); st_d = drt_pkg::ST_DONE;
          end else begin
            ra = IdxW'(i_q - NW'(1)); st_d = drt_pkg::ST_SHIFT;
          end
        end
      end
      drt_pkg::ST_SHIFT: begin
        we = 1'b1; wa = i_q[IdxW-1:0]; wd = rd;
        st_d = drt_pkg::ST_SHIFT_REQ;
        i_d = (w_q == NW'(1)) ? i_q + NW'(1) : i_q - NW'(1);
      end
      default: st_d = drt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == drt_pkg::ST_SCAN && !lof_q && re < b_q) ps_q <= rs;
  end

  ast_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.last |=> !busy_o || !strobe_o) else $error("last then busy");
  ast_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MaxRanges)) else $error("count overflow");
  ast_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !we) else $error("write while idle");
endmodule
`default_nettype wire

// ===== rtl/drt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module drt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
